### hw/rtl/crcaug_pkg.sv
package crcaug_pkg;

  // Default width of the remainder in bytes.
  localparam int unsigned CRC_BYTES_DEF = 4;

  localparam int unsigned CNT_W   = 32;
  localparam int unsigned POLY_W  = 32;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [POLY_W-1:0] POLY_RESET = 32'h0000_0002;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  // Byte address of the polynomial register.
  localparam logic [APB_AW-1:0] ADDR_POLY = 3'd0;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_FINISH = 1'b1
  } kind_e;

endpackage

### hw/rtl/crcaug_step.sv
module crcaug_step #(
  parameter int unsigned Width = 32
) (
  input  logic [Width-1:0] rem_i,
  input  logic [Width-1:0] poly_i,
  input  logic [7:0]       byte_i,
  output logic [Width-1:0] rem_o
);

  // Eight bit steps of the long division, most significant message bit first.
  always_comb begin
    logic [Width-1:0] r;
    logic             top;
    r = rem_i;
    for (int k = 0; k < 8; k++) begin
      top = r[Width-1];
      r   = {r[Width-2:0], byte_i[3'(7 - k)]};
      if (top) begin
        r = r ^ poly_i;
      end
    end
    rem_o = r;
  end

endmodule

### hw/rtl/crc32_augmented_division.sv
// CRC by plain polynomial long division, MSB first, zero start value and no
// final XOR. The polynomial register (byte address 0, reset 0x2) holds the
// generator without its leading one; it must be written only while the block
// is idle. Each input transaction carries kind in tuser (0 = data byte,
// 1 = finish) and the byte in tdata. Both sides move one transaction per
// cycle unless m_axis_tready stalls the pipeline. A data byte is folded into
// the running remainder in the cycle it is accepted and produces no output.
// A finish hands the remainder and the byte count to an augmentation pipeline
// whose first stage captures them and whose CRC_BYTES later stages each shift
// in eight zero bits, and clears both for the next message at once; its
// result (crc_value in tdata bits 31:0, byte_total in bits 63:32) is offered
// from the last stage. The byte count saturates at 0xFFFFFFFF.
module crc32_augmented_division #(
  parameter int unsigned CRC_BYTES = crcaug_pkg::CRC_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crcaug_pkg::APB_AW-1:0] paddr,
  input  logic [crcaug_pkg::APB_DW-1:0] pwdata,
  output logic [crcaug_pkg::APB_DW-1:0] prdata,
  output logic                          pready,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tuser,  // [0] kind
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata   // [31:0] crc_value, [63:32] byte_total
);
  import crcaug_pkg::*;

  localparam int unsigned CrcW = 8 * CRC_BYTES;
  localparam int unsigned NStg = CRC_BYTES + 1;

  logic [POLY_W-1:0] poly_q, poly_d;
  logic [CrcW-1:0]   poly_w;
  logic [CrcW+POLY_W-1:0] poly_ext;

  logic [CrcW-1:0]  rem_q, rem_d, rem_byte;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             in_acc;
  logic             cfg_wr;

  logic [NStg-1:0]  vld_q, vld_d;
  logic [NStg-1:0]  stg_rdy;
  logic [CrcW-1:0]  srem_q [NStg];
  logic [CNT_W-1:0] scnt_q [NStg];
  logic [CrcW-1:0]  srem_nxt [NStg-1];

  logic [CrcW+31:0] crc_ext;

  // Configuration
  assign pready = 1'b1;
  assign prdata = poly_q;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_POLY);
  assign poly_d = cfg_wr ? pwdata : poly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= POLY_RESET;
    end else begin
      poly_q <= poly_d;
    end
  end

  // The polynomial is cut or zero-extended to the remainder width.
  assign poly_ext = {{CrcW{1'b0}}, poly_q};
  assign poly_w   = poly_ext[CrcW-1:0];

  // Running remainder and byte count
  assign s_axis_tready = stg_rdy[0];
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  crcaug_step #(.Width(CrcW)) u_data_step (
    .rem_i  (rem_q),
    .poly_i (poly_w),
    .byte_i (s_axis_tdata),
    .rem_o  (rem_byte)
  );

  always_comb begin
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      case (kind_e'(s_axis_tuser))
        KIND_DATA: begin
          rem_d = rem_byte;
          if (cnt_q != CNT_MAX) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        KIND_FINISH: begin
          rem_d = '0;
          cnt_d = '0;
        end
        default: begin
          rem_d = rem_q;
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      cnt_q <= '0;
    end else begin
      rem_q <= rem_d;
      cnt_q <= cnt_d;
    end
  end

  // Augmentation pipeline: stage 0 holds the captured remainder, every later
  // stage has shifted in eight more zero bits.
  assign stg_rdy[NStg-1] = !vld_q[NStg-1] || m_axis_tready;

  for (genvar j = 0; j < NStg - 1; j++) begin : g_aug
    assign stg_rdy[j] = !vld_q[j] || stg_rdy[j+1];

    crcaug_step #(.Width(CrcW)) u_aug_step (
      .rem_i  (srem_q[j]),
      .poly_i (poly_w),
      .byte_i (8'h00),
      .rem_o  (srem_nxt[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[0]) begin
      srem_q[0] <= rem_q;
      scnt_q[0] <= cnt_q;
    end
    for (int j = 1; j < NStg; j++) begin
      if (stg_rdy[j]) begin
        srem_q[j] <= srem_nxt[j-1];
        scnt_q[j] <= scnt_q[j-1];
      end
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (stg_rdy[0]) begin
      vld_d[0] = in_acc && (kind_e'(s_axis_tuser) == KIND_FINISH);
    end
    for (int j = 1; j < NStg; j++) begin
      if (stg_rdy[j]) begin
        vld_d[j] = vld_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign crc_ext       = {32'h0, srem_q[NStg-1]};
  assign m_axis_tvalid = vld_q[NStg-1];
  assign m_axis_tdata  = {scnt_q[NStg-1], crc_ext[31:0]};

endmodule

### hw/rtl/crcaug_checker.sv
module crcaug_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic [7:0] pend_q;
  logic       fin_acc;
  logic       out_acc;

  assign fin_acc = s_axis_tvalid && s_axis_tready && s_axis_tuser;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Finish transactions accepted whose results are not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(fin_acc) - 8'(out_acc);
    end
  end

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pend_q != 8'd0))
    else $error("result offered without a pending finish transaction");

  a_idle_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 8'd0) |-> s_axis_tready)
    else $error("input stalled with no result outstanding");

  a_poly_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr == 3'd0)) |=> (prdata == $past(pwdata)))
    else $error("polynomial register does not read back the written value");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind crc32_augmented_division crcaug_checker u_crcaug_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### bench/crc32_augmented_division_tb.sv
module crc32_augmented_division_tb;
  import crcaug_pkg::*;

  localparam int unsigned DRAIN_CYCLES = CRC_BYTES_DEF + 8;
  localparam int unsigned TIMEOUT_UNITS = 5_000_000;
  // An address past the only register; writes there must not land anywhere.
  localparam logic [APB_AW-1:0] ADDR_UNUSED = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0]  total;
    logic [POLY_W-1:0] crc;
  } crc_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [7:0] data_byte
  logic                s_axis_tuser;   // [0] kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;   // [31:0] crc_value, [63:32] byte_total

  // Mirror of the block: polynomial register, running remainder, byte count.
  logic [POLY_W-1:0]   poly_q;
  logic [31:0]         rem_q;
  logic [CNT_W-1:0]    count_q;
  crc_result_t         crc_results_q[$];

  int unsigned         mismatches = 0;
  int unsigned         send_idle_pct = 18;
  int unsigned         recv_idle_pct = 75;

  crc32_augmented_division DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_UNITS);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] divide_byte(input logic [31:0] rem, input logic [7:0] b,
                                              input logic [31:0] poly);
    logic [31:0] r;
    logic        top;
    r = rem;
    for (int k = 7; k >= 0; k--) begin
      top = r[31];
      r = {r[30:0], b[k]};
      if (top) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  // Updates the mirror for one accepted transaction on the input stream.
  task automatic predict_crc(input kind_e kind, input logic [7:0] b);
    crc_result_t res;
    if (kind == KIND_DATA) begin
      rem_q = divide_byte(rem_q, b, poly_q);
      if (count_q != CNT_MAX) begin
        count_q = count_q + 1;
      end
    end else begin
      res.crc = rem_q;
      // The augmentation: one zero byte per remainder byte.
      repeat (CRC_BYTES_DEF) res.crc = divide_byte(res.crc, 8'h00, poly_q);
      res.total = count_q;
      crc_results_q.push_back(res);
      rem_q = '0;
      count_q = '0;
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %h, got %h", what, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    crc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (crc_results_q.size() == 0) begin
        note_mismatch("unexpected result", 64'h0, m_axis_tdata);
      end else begin
        want = crc_results_q.pop_front();
        if (m_axis_tdata[31:0] !== want.crc) begin
          note_mismatch("crc_value", {32'h0, want.crc}, {32'h0, m_axis_tdata[31:0]});
        end
        if (m_axis_tdata[63:32] !== want.total) begin
          note_mismatch("byte_total", {32'h0, want.total}, {32'h0, m_axis_tdata[63:32]});
        end
      end
    end
  end

  // All stream and bus tasks are entered and left at a falling edge.
  task automatic send_item(input kind_e kind, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_crc(kind, b);
    @(negedge clk_i);
  endtask

  task automatic send_message(input int unsigned len);
    repeat (len) send_item(KIND_DATA, 8'($urandom_range(255)));
    send_item(KIND_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic hold_stream;
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_results_done;
    while (crc_results_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic wait_idle;
    hold_stream();
    wait_results_done();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_POLY) begin
      poly_q = value;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_polynomial;
    logic [APB_DW-1:0] got;
    psel    = 1'b1;
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = ADDR_POLY;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== poly_q) begin
      note_mismatch("polynomial readback", {32'h0, poly_q}, {32'h0, got});
    end
  endtask

  task automatic set_polynomial(input logic [APB_DW-1:0] value);
    wait_idle();
    apb_write(ADDR_POLY, value);
    check_polynomial();
  endtask

  function automatic logic [31:0] pick_polynomial;
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      4: return 32'h04C1_1DB7;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_polynomial;
    check_polynomial();
    send_item(KIND_DATA, 8'h80);
    send_item(KIND_DATA, 8'h01);
    send_item(KIND_FINISH, 8'h00);
  endtask

  // Finishes with no data between them must report zero, whatever the
  // ignored byte on the finish transaction holds.
  task automatic test_empty_message;
    send_item(KIND_FINISH, 8'hFF);
    send_item(KIND_FINISH, 8'h5A);
  endtask

  task automatic test_polynomial_extremes;
    set_polynomial(32'hFFFF_FFFF);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_FINISH, 8'hFF);
    set_polynomial(32'h0000_0000);
    send_item(KIND_DATA, 8'hA5);
    send_item(KIND_FINISH, 8'h00);
    set_polynomial(32'h8000_0000);
    send_item(KIND_DATA, 8'h01);
    send_item(KIND_DATA, 8'h80);
    send_item(KIND_FINISH, 8'hFF);
    set_polynomial(32'h04C1_1DB7);
    send_item(KIND_DATA, 8'h31);
    send_item(KIND_DATA, 8'h32);
    send_item(KIND_DATA, 8'h33);
    send_item(KIND_FINISH, 8'h00);
  endtask

  task automatic test_unused_address;
    wait_idle();
    apb_write(ADDR_UNUSED, 32'h1234_5678);
    check_polynomial();
    send_item(KIND_DATA, 8'h7E);
    send_item(KIND_FINISH, 8'h81);
  endtask

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned msgs;
    sent = 0;
    msgs = 0;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    set_polynomial(pick_polynomial());
    while (sent < n_items) begin
      if ($urandom_range(15) == 0) begin
        len = $urandom_range(200, 40);
      end else begin
        len = $urandom_range(24, 0);
      end
      send_message(len);
      sent += len + 1;
      msgs++;
      if (msgs % 8 == 0) begin
        set_polynomial(pick_polynomial());
      end else if ($urandom_range(19) == 0) begin
        // Let the result side run dry before the next message starts.
        hold_stream();
        wait_results_done();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = ADDR_POLY;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_DATA;
    poly_q        = POLY_RESET;
    rem_q         = '0;
    count_q       = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_polynomial();
    test_empty_message();
    test_polynomial_extremes();
    test_unused_address();
    test_random_traffic(18, 75, 410);
    test_random_traffic(75, 18, 410);
    test_random_traffic(0, 0, 410);

    wait_idle();
    if (mismatches == 0 && crc_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/crcaug_pkg.sv
hw/rtl/crcaug_step.sv
hw/rtl/crc32_augmented_division.sv
hw/rtl/crcaug_checker.sv
bench/crc32_augmented_division_tb.sv
